FILE: rtl/grc_pkg.sv
package grc_pkg;

  localparam int IN_W  = 120;
  localparam int OUT_W = 80;
  localparam int SH_W  = 12;

  localparam logic [SH_W-1:0] SH_RESET   = 12'd600;
  localparam logic [11:0]     HEIGHT_MAX = 12'd4095;

  typedef enum logic [1:0] {
    DIV_X,
    DIV_Y,
    DIV_H
  } div_sel_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DX_GO,
    S_DX_WAIT,
    S_DY_GO,
    S_DY_WAIT,
    S_MUL_X,
    S_MUL_Y,
    S_SET_Y,
    S_STEP,
    S_PROBE,
    S_CHECK,
    S_CORR_MUL,
    S_CORR_SAT,
    S_HT_GO,
    S_HT_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     clr;
    logic     div_start;
    div_sel_t div_sel;
    logic     save_dx;
    logic     save_dy;
    logic     mul_x;
    logic     mul_y;
    logic     mul_r;
    logic     set_sx;
    logic     set_sy;
    logic     set_corr;
    logic     step;
    logic     probe;
    logic     save_h;
    logic     out_load;
  } grc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic outside;
    logic wall;
    logic last_step;
  } grc_stat_t;

endpackage

FILE: rtl/grid_ray_caster_unit.sv
// Sequence: a map write item is stored as it is taken; a cast item runs a divide on the
// bit-serial divider for each of dir_x and dir_y, the start multiplies, then steps, reads the
// map and checks once per cell walked until a wall, at most 2 * MAP_SIZE + 4 cells, or until
// the ray leaves the grid; then the view_cos correction and a third divide for the wall height.
// Throughput: one item at a time; the next is taken in the cycle after a result is loaded.
// Reset: rst sweeps every map entry clear, taking no item until the sweep ends.
module grid_ray_caster_unit #(
  parameter int MAP_SIZE = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cell_x, cell_y, cell_wall, origin_x, origin_y, dir_x, dir_y, view_cos,
  // vertical_offset, walk_offset, zero fill
  input  logic [119:0] s_tdata,
  // command
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit_cell_x, hit_cell_y, hit_vertical, distance, wall_height, draw_start,
  // draw_end, zero fill
  output logic [79:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [11:0]  cfg_data
);
  import grc_pkg::*;

  grc_cmd_t  cmd;
  grc_stat_t st;

  assign cfg_ready = 1'b1;

  grc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .st       (st)
  );

  grc_dp #(.MAP_SIZE(MAP_SIZE)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .in_data  (s_tdata),
    .in_user  (s_tuser),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .out_data (m_tdata)
  );

`ifndef SYNTHESIS
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> !s_tready)
    else $error("block took an item while a cast was under way");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");

  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !st.div_done)
    else $error("divider finished too early");
`endif

endmodule

FILE: rtl/grc_div.sv
module grc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [23:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);

  logic [23:0] rem;
  logic [31:0] quo;
  logic [23:0] dsr;
  logic [4:0]  cnt;
  logic        busy;
  logic [24:0] trial;
  logic        take;

  // One quotient bit a cycle, restoring form; the dividend shifts out of quo.
  assign trial = {rem, quo[31]};
  assign take  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= take ? 24'(trial - {1'b0, dsr}) : trial[23:0];
      quo <= {quo[30:0], take};
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/grc_ctrl.sv
module grc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output grc_pkg::grc_cmd_t    cmd,
  input  grc_pkg::grc_stat_t   st
);
  import grc_pkg::*;

  state_t state, state_next;
  logic   out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (st.clr_last) state_next = S_IDLE;
      S_IDLE:     if (s_tvalid && s_tuser) state_next = S_DX_GO;
      S_DX_GO:    state_next = S_DX_WAIT;
      S_DX_WAIT:  if (st.div_done) state_next = S_DY_GO;
      S_DY_GO:    state_next = S_DY_WAIT;
      S_DY_WAIT:  if (st.div_done) state_next = S_MUL_X;
      S_MUL_X:    state_next = S_MUL_Y;
      S_MUL_Y:    state_next = S_SET_Y;
      S_SET_Y:    state_next = S_STEP;
      S_STEP:     state_next = S_PROBE;
      S_PROBE:    state_next = st.outside ? S_CORR_MUL : S_CHECK;
      S_CHECK:    state_next = (st.wall || st.last_step) ? S_CORR_MUL : S_STEP;
      S_CORR_MUL: state_next = S_CORR_SAT;
      S_CORR_SAT: state_next = S_HT_GO;
      S_HT_GO:    state_next = S_HT_WAIT;
      S_HT_WAIT:  if (st.div_done) state_next = S_DONE;
      S_DONE:     if (!out_valid || m_tready) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_DX_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_X;
      end
      S_DX_WAIT: begin
        cmd.div_sel = DIV_X;
        cmd.save_dx = st.div_done;
      end
      S_DY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_Y;
      end
      S_DY_WAIT: begin
        cmd.div_sel = DIV_Y;
        cmd.save_dy = st.div_done;
      end
      S_MUL_X: cmd.mul_x = 1'b1;
      S_MUL_Y: begin
        cmd.set_sx = 1'b1;
        cmd.mul_y  = 1'b1;
      end
      S_SET_Y:    cmd.set_sy = 1'b1;
      S_STEP:     cmd.step = 1'b1;
      S_PROBE:    cmd.probe = !st.outside;
      S_CORR_MUL: cmd.mul_r = 1'b1;
      S_CORR_SAT: cmd.set_corr = 1'b1;
      S_HT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_H;
      end
      S_HT_WAIT: begin
        cmd.div_sel = DIV_H;
        cmd.save_h  = st.div_done;
      end
      S_DONE: cmd.out_load = !out_valid || m_tready;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/grc_dp.sv
module grc_dp #(
  parameter int MAP_SIZE = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  grc_pkg::grc_cmd_t           cmd,
  output grc_pkg::grc_stat_t          st,
  input  logic [grc_pkg::IN_W-1:0]    in_data,
  input  logic                        in_user,
  input  logic                        cfg_we,
  input  logic [grc_pkg::SH_W-1:0]    cfg_data,
  output logic [grc_pkg::OUT_W-1:0]   out_data
);
  import grc_pkg::*;

  localparam int LB    = $clog2(MAP_SIZE);
  localparam int AW    = 2 * LB;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = (LB + 2 > 6) ? LB + 2 : 6;
  localparam int XW    = (LB > 4) ? LB : 4;
  localparam int STEPS = 2 * MAP_SIZE + 4;
  localparam int NW    = $clog2(STEPS + 1);

  logic [3:0]  f_cx, f_cy;
  logic        f_wall;
  logic [19:0] f_ox, f_oy;
  logic [15:0] f_dx, f_dy;
  logic [14:0] f_vcos;
  logic [11:0] f_voff;
  logic [5:0]  f_woff;

  assign f_cx   = in_data[3:0];
  assign f_cy   = in_data[7:4];
  assign f_wall = in_data[8];
  assign f_ox   = in_data[28:9];
  assign f_oy   = in_data[48:29];
  assign f_dx   = in_data[64:49];
  assign f_dy   = in_data[80:65];
  assign f_vcos = in_data[95:81];
  assign f_voff = in_data[107:96];
  assign f_woff = in_data[113:108];

  logic [SH_W-1:0] sh;
  always_ff @(posedge clk) begin
    if (rst) begin
      sh <= SH_RESET;
    end else if (cfg_we) begin
      sh <= cfg_data;
    end
  end

  // Wall map: cleared by a sweep after reset, one entry a cycle.
  logic          map_mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en, wr_bit, rd_bit;
  logic [XW-1:0] cxe, cye;
  logic          in_map;

  assign cxe    = XW'(f_cx);
  assign cye    = XW'(f_cy);
  assign in_map = (int'(f_cx) < MAP_SIZE) && (int'(f_cy) < MAP_SIZE);
  assign wr_en  = cmd.clr || (cmd.load && !in_user && in_map);
  assign wr_addr = cmd.clr ? clr_addr : {cye[LB-1:0], cxe[LB-1:0]};
  assign wr_bit  = cmd.clr ? 1'b0 : f_wall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_bit;
    if (cmd.probe) rd_bit <= map_mem[rd_addr];
  end

  // Ray state.
  logic               negx, negy;
  logic [15:0]        magx, magy;
  logic [16:0]        fx, fy;
  logic [31:0]        ddx, ddy;
  logic [39:0]        sx, sy, raw;
  logic signed [CW-1:0] tx, ty;
  logic               vert;
  logic [14:0]        vcos;
  logic [11:0]        voff;
  logic [5:0]         woff;
  logic [NW-1:0]      cnt;
  logic [54:0]        prod;
  logic [23:0]        corr;
  logic [11:0]        h;

  logic [31:0] div_n, div_q;
  logic [23:0] div_d;
  logic        div_done;

  always_comb begin
    case (cmd.div_sel)
      DIV_X: begin
        div_n = 32'h8000_0000;
        div_d = 24'(magx);
      end
      DIV_Y: begin
        div_n = 32'h8000_0000;
        div_d = 24'(magy);
      end
      DIV_H: begin
        div_n = {4'b0, sh, 16'b0};
        div_d = corr;
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  grc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (div_q),
    .done     (div_done)
  );

  logic [48:0] mul_xy;
  logic [54:0] mul_rc;
  logic [39:0] corr_full;

  assign mul_xy    = cmd.mul_y ? 49'(fy) * 49'(ddy) : 49'(fx) * 49'(ddx);
  assign mul_rc    = 55'(raw) * 55'(vcos);
  assign corr_full = prod[54:15];

  always_ff @(posedge clk) begin
    if (cmd.load && in_user) begin
      negx <= f_dx[15];
      negy <= f_dy[15];
      magx <= f_dx[15] ? 16'(-f_dx) : f_dx;
      magy <= f_dy[15] ? 16'(-f_dy) : f_dy;
      fx   <= f_dx[15] ? {1'b0, f_ox[15:0]} : 17'(17'h10000 - {1'b0, f_ox[15:0]});
      fy   <= f_dy[15] ? {1'b0, f_oy[15:0]} : 17'(17'h10000 - {1'b0, f_oy[15:0]});
      tx   <= CW'(f_ox[19:16]);
      ty   <= CW'(f_oy[19:16]);
      vcos <= f_vcos;
      voff <= f_voff;
      woff <= f_woff;
      cnt  <= '0;
    end
    if (cmd.save_dx) ddx <= (magx == '0) ? '1 : div_q;
    if (cmd.save_dy) ddy <= (magy == '0) ? '1 : div_q;
    if (cmd.mul_x || cmd.mul_y) prod <= 55'(mul_xy);
    if (cmd.mul_r) prod <= mul_rc;
    if (cmd.set_sx) sx <= 40'(prod[48:16]);
    if (cmd.set_sy) sy <= 40'(prod[48:16]);
    if (cmd.step) begin
      cnt <= cnt + 1'b1;
      // Equal crossings step along y.
      if (sx < sy) begin
        raw  <= sx;
        sx   <= sx + 40'(ddx);
        tx   <= negx ? tx - 1'b1 : tx + 1'b1;
        vert <= 1'b1;
      end else begin
        raw  <= sy;
        sy   <= sy + 40'(ddy);
        ty   <= negy ? ty - 1'b1 : ty + 1'b1;
        vert <= 1'b0;
      end
    end
    if (cmd.set_corr) corr <= (|corr_full[39:24]) ? '1 : corr_full[23:0];
    if (cmd.save_h) begin
      if (corr == '0 || |div_q[31:12]) h <= HEIGHT_MAX;
      else h <= div_q[11:0];
    end
  end

  assign rd_addr = {ty[LB-1:0], tx[LB-1:0]};

  logic signed [15:0] start_w, end_w;
  assign start_w = $signed({5'b0, sh[11:1]}) - 16'(signed'(voff))
                   - $signed({5'b0, h[11:1]}) + 16'(signed'(woff));
  assign end_w   = start_w + $signed({4'b0, h});

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {3'b0, end_w[13:0], start_w[13:0], h, corr, vert,
                   ty[5:0], tx[5:0]};
    end
  end

  assign st.clr_last  = &clr_addr;
  assign st.div_done  = div_done;
  assign st.outside   = tx[CW-1] || ty[CW-1] ||
                        (tx >= $signed(CW'(MAP_SIZE))) || (ty >= $signed(CW'(MAP_SIZE)));
  assign st.wall      = rd_bit;
  assign st.last_step = (cnt == NW'(STEPS));

endmodule
